@@ hdl/jads_pkg.sv @@
// shared constants for the joystick axis dead-zone scaler
// register map, apb sizes and default widths; no dependencies
`timescale 1ns / 1ps

package jads_pkg;

    localparam int ADC_BITS_DEF   = 10;
    localparam int FULL_SCALE_DEF = 255;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_CENTER_POS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_POS    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEAD_ZONE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_CHANGE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INVERT     = 3'd4;

endpackage

@@ hdl/jads_cfg_regs.sv @@
// apb register bank holding centre, range, dead zone, minimum change and invert
// depends on jads_pkg
`timescale 1ns / 1ps

module jads_cfg_regs #(
    parameter int ADC_BITS = jads_pkg::ADC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jads_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [jads_pkg::APB_DATA_W-1:0] pwdata,
    output logic [jads_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [ADC_BITS-1:0]             center_pos,
    output logic [ADC_BITS:0]               max_pos,
    output logic [ADC_BITS-1:0]             dead_zone,
    output logic [ADC_BITS-1:0]             min_change,
    output logic                            invert
);

    localparam logic [ADC_BITS-1:0] CENTER_RST = ADC_BITS'(1) << (ADC_BITS - 1);
    localparam logic [ADC_BITS:0]   MAX_RST    = (ADC_BITS + 1)'(1) << ADC_BITS;

    logic [ADC_BITS-1:0]            center_pos_reg;
    logic [ADC_BITS:0]              max_pos_reg;
    logic [ADC_BITS-1:0]            dead_zone_reg;
    logic [ADC_BITS-1:0]            min_change_reg;
    logic                           invert_reg;
    logic                           wr_en;
    logic [jads_pkg::REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[jads_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_pos_reg <= CENTER_RST;
            max_pos_reg    <= MAX_RST;
            dead_zone_reg  <= '0;
            min_change_reg <= '0;
            invert_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                jads_pkg::REG_CENTER_POS: center_pos_reg <= pwdata[ADC_BITS-1:0];
                jads_pkg::REG_MAX_POS:    max_pos_reg    <= pwdata[ADC_BITS:0];
                jads_pkg::REG_DEAD_ZONE:  dead_zone_reg  <= pwdata[ADC_BITS-1:0];
                jads_pkg::REG_MIN_CHANGE: min_change_reg <= pwdata[ADC_BITS-1:0];
                jads_pkg::REG_INVERT:     invert_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            jads_pkg::REG_CENTER_POS: prdata = jads_pkg::APB_DATA_W'(center_pos_reg);
            jads_pkg::REG_MAX_POS:    prdata = jads_pkg::APB_DATA_W'(max_pos_reg);
            jads_pkg::REG_DEAD_ZONE:  prdata = jads_pkg::APB_DATA_W'(dead_zone_reg);
            jads_pkg::REG_MIN_CHANGE: prdata = jads_pkg::APB_DATA_W'(min_change_reg);
            jads_pkg::REG_INVERT:     prdata = jads_pkg::APB_DATA_W'(invert_reg);
            default:                  prdata = '0;
        endcase
    end

    assign center_pos = center_pos_reg;
    assign max_pos    = max_pos_reg;
    assign dead_zone  = dead_zone_reg;
    assign min_change = min_change_reg;
    assign invert     = invert_reg;

endmodule

@@ hdl/jads_serial_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// standalone; used by the scaler top level
`timescale 1ns / 1ps

module jads_serial_div #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = ~trial[DEN_W+1];

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            rem_next = '0;
            quo_next = numer;
            den_next = denom;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
            rem_next  = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/joystick_axis_deadzone_scaler_unit.sv @@
// joystick axis dead-zone scaler, top level: control sequencer and output word
// depends on jads_pkg, jads_cfg_regs and jads_serial_div
`timescale 1ns / 1ps

// usage
// - input channel: in_valid / in_ready carry one word, the raw sample
// - output channel: out_valid / out_ready carry one word per sample:
//   axis_value (signed) and updated
// - apb port sets centre, max position, dead zone, minimum change and invert;
//   write only while no sample is in flight
// - one sample at a time; in_ready is high only while the sequencer is idle
// - a sample that is rejected, lies in the dead zone or has a zero range goes
//   from evaluation straight to the output stage, skipping multiply and divide
// - a scaled sample goes through evaluation, multiply, the bit-serial divider
//   (one quotient bit a cycle) and the output stage
// - the next sample is taken from the cycle after the word reaches the output
//   register
// - a finished word waits in the sequencer while the output register is still
//   held by a stalled receiver; nothing is dropped
// - reset clears the registers to their defaults, forgets the last position and
//   sets the held value to zero; the first sample after reset is always taken

module joystick_axis_deadzone_scaler_unit #(
    parameter int ADC_BITS   = jads_pkg::ADC_BITS_DEF,
    parameter int FULL_SCALE = jads_pkg::FULL_SCALE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jads_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [jads_pkg::APB_DATA_W-1:0] pwdata,
    output logic [jads_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ADC_BITS-1:0]             sample,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [$clog2(FULL_SCALE+1):0] axis_value,
    output logic                            updated
);

    localparam int MAG_W = $clog2(FULL_SCALE + 1);
    localparam int VAL_W = MAG_W + 1;
    localparam int RNG_W = ADC_BITS + 1;
    localparam int NUM_W = ADC_BITS + MAG_W;
    localparam logic [MAG_W-1:0] MAG_FULL = MAG_W'(FULL_SCALE);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [ADC_BITS-1:0] center_pos;
    logic [ADC_BITS:0]   max_pos;
    logic [ADC_BITS-1:0] dead_zone;
    logic [ADC_BITS-1:0] min_change;
    logic                invert;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [ADC_BITS-1:0] sample_reg;
    logic [ADC_BITS-1:0] sample_next;
    logic                keep_reg;
    logic                keep_next;
    logic                neg_reg;
    logic                neg_next;
    logic [MAG_W-1:0]    mag_reg;
    logic [MAG_W-1:0]    mag_next;
    logic [ADC_BITS-1:0] dist_reg;
    logic [ADC_BITS-1:0] dist_next;
    logic [RNG_W-1:0]    range_reg;
    logic [RNG_W-1:0]    range_next;

    logic [ADC_BITS-1:0] last_pos_reg;
    logic [ADC_BITS-1:0] last_pos_next;
    logic                pos_valid_reg;
    logic                pos_valid_next;
    logic [VAL_W-1:0]    held_value_reg;
    logic [VAL_W-1:0]    held_value_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VAL_W-1:0]    axis_value_reg;
    logic [VAL_W-1:0]    axis_value_next;
    logic                updated_reg;
    logic                updated_next;

    logic [ADC_BITS-1:0] diff_last;
    logic                changed;
    logic                above;
    logic [ADC_BITS-1:0] dist_ctr;
    logic                in_dead;
    logic [RNG_W-1:0]    upper_range;
    logic [RNG_W-1:0]    range_sel;
    logic [NUM_W-1:0]    product;
    logic                div_start;
    logic                div_done;
    logic [NUM_W-1:0]    quotient;
    logic [VAL_W-1:0]    mag_ext;
    logic [VAL_W-1:0]    result_value;
    logic                out_free;

    jads_cfg_regs #(
        .ADC_BITS (ADC_BITS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .center_pos (center_pos),
        .max_pos    (max_pos),
        .dead_zone  (dead_zone),
        .min_change (min_change),
        .invert     (invert)
    );

    jads_serial_div #(
        .NUM_W (NUM_W),
        .DEN_W (RNG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (product),
        .denom    (range_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // evaluation of a captured sample
    assign diff_last   = (sample_reg > last_pos_reg) ? sample_reg - last_pos_reg
                                                     : last_pos_reg - sample_reg;
    assign changed     = ~pos_valid_reg | (diff_last > min_change);
    assign above       = sample_reg > center_pos;
    assign dist_ctr    = above ? sample_reg - center_pos : center_pos - sample_reg;
    assign in_dead     = (dist_ctr < dead_zone) | (dist_ctr == '0);
    assign upper_range = (max_pos > {1'b0, center_pos}) ? max_pos - {1'b0, center_pos}
                                                         : '0;
    assign range_sel   = above ? upper_range : {1'b0, center_pos};

    assign product      = NUM_W'(dist_reg) * NUM_W'(FULL_SCALE);
    assign div_start    = (state_reg == ST_MUL);
    assign mag_ext      = {1'b0, mag_reg};
    assign result_value = (neg_reg ^ invert) ? VAL_W'(0) - mag_ext : mag_ext;
    assign out_free     = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next      = state_reg;
        sample_next     = sample_reg;
        keep_next       = keep_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        dist_next       = dist_reg;
        range_next      = range_reg;
        last_pos_next   = last_pos_reg;
        pos_valid_next  = pos_valid_reg;
        held_value_next = held_value_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        axis_value_next = axis_value_reg;
        updated_next    = updated_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                keep_next  = ~changed;
                neg_next   = ~above;
                dist_next  = dist_ctr;
                range_next = range_sel;
                if (!changed || in_dead)
                begin
                    mag_next   = '0;
                    state_next = ST_FIN;
                end
                else if (range_sel == '0)
                begin
                    mag_next   = MAG_FULL;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mag_next   = (quotient > NUM_W'(FULL_SCALE)) ? MAG_FULL
                                                                 : quotient[MAG_W-1:0];
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    updated_next   = ~keep_reg;
                    if (keep_reg)
                    begin
                        axis_value_next = held_value_reg;
                    end
                    else
                    begin
                        axis_value_next = result_value;
                        held_value_next = result_value;
                        last_pos_next   = sample_reg;
                        pos_valid_next  = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_pos_reg   <= '0;
            pos_valid_reg  <= 1'b0;
            held_value_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_pos_reg   <= last_pos_next;
            pos_valid_reg  <= pos_valid_next;
            held_value_reg <= held_value_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        keep_reg       <= keep_next;
        neg_reg        <= neg_next;
        mag_reg        <= mag_next;
        dist_reg       <= dist_next;
        range_reg      <= range_next;
        axis_value_reg <= axis_value_next;
        updated_reg    <= updated_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign axis_value = $signed(axis_value_reg);
    assign updated    = updated_reg;

    // a repeated word carries the held value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !updated |-> axis_value_reg == held_value_reg)
        else $error("repeated word differs from held value");

    // magnitude never exceeds full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (axis_value <= $signed(VAL_W'(FULL_SCALE)))
                   && (axis_value >= -$signed(VAL_W'(FULL_SCALE))))
        else $error("axis value beyond full scale");

    // the divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside divide phase");

    // any word on the output implies a position has been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pos_valid_reg)
        else $error("output word before first accepted position");

endmodule

@@ test/jads_axis_checker.sv @@
// checker for the joystick axis dead-zone scaler: follows the register port and
// both word channels, predicts every output word and compares it field by field
// depends on jads_pkg
`timescale 1ns / 1ps

module jads_axis_checker #(
    parameter int ADC_BITS   = jads_pkg::ADC_BITS_DEF,
    parameter int FULL_SCALE = jads_pkg::FULL_SCALE_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [jads_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [jads_pkg::APB_DATA_W-1:0]        pwdata,
    input  logic [jads_pkg::APB_DATA_W-1:0]        prdata,
    input  logic                                   pready,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic [ADC_BITS-1:0]                    sample,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [$clog2(FULL_SCALE+1):0]   axis_value,
    input  logic                                   updated,
    output int                                     errors,
    output int                                     pending,
    output int                                     checked,
    output int                                     recomputed
);

    localparam int VALUE_W      = $clog2(FULL_SCALE + 1) + 1;
    localparam int CENTER_RESET = 1 << (ADC_BITS - 1);
    localparam int MAX_RESET    = 1 << ADC_BITS;

    typedef struct {
        logic signed [VALUE_W-1:0] axis_value;
        logic                      updated;
    } axis_word_t;

    // register copies
    logic [ADC_BITS-1:0] cfg_center;
    logic [ADC_BITS:0]   cfg_max_pos;
    logic [ADC_BITS-1:0] cfg_dead_zone;
    logic [ADC_BITS-1:0] cfg_min_change;
    logic                cfg_invert;

    // axis state
    logic [ADC_BITS-1:0]       last_pos;
    logic                      have_pos;
    logic signed [VALUE_W-1:0] held_value;

    axis_word_t axis_words_q[$];
    axis_word_t want;

    logic [jads_pkg::REG_IDX_W-1:0] reg_idx;
    logic [jads_pkg::APB_DATA_W-1:0] reg_want;
    logic                            reg_known;
    string                           reg_name;

    assign reg_idx = paddr[jads_pkg::APB_ADDR_W-1:2];

    function automatic axis_word_t predict_word(input logic [ADC_BITS-1:0] pos);
        axis_word_t w;
        int         p;
        int         c;
        int         last;
        int         offset;
        int         span;
        int         mag;
        int         value;
        logic       take;
        p    = int'(pos);
        c    = int'(cfg_center);
        last = int'(last_pos);
        take = !have_pos || (((p > last) ? p - last : last - p) > int'(cfg_min_change));
        if (take)
        begin
            offset = (p > c) ? p - c : c - p;
            if (offset < int'(cfg_dead_zone) || offset == 0)
                value = 0;
            else if (p > c)
            begin
                span  = int'(cfg_max_pos) - c;
                mag   = (span <= 0) ? FULL_SCALE : offset * FULL_SCALE / span;
                value = (mag > FULL_SCALE) ? FULL_SCALE : mag;
            end
            else
            begin
                mag   = offset * FULL_SCALE / c;
                value = -((mag > FULL_SCALE) ? FULL_SCALE : mag);
            end
            if (cfg_invert)
                value = -value;
            held_value = VALUE_W'(value);
            last_pos   = pos;
            have_pos   = 1'b1;
        end
        w.axis_value = held_value;
        w.updated    = take;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_center     = ADC_BITS'(CENTER_RESET);
            cfg_max_pos    = (ADC_BITS + 1)'(MAX_RESET);
            cfg_dead_zone  = '0;
            cfg_min_change = '0;
            cfg_invert     = 1'b0;
            last_pos       = '0;
            have_pos       = 1'b0;
            held_value     = '0;
            axis_words_q.delete();
            errors         = 0;
            pending        = 0;
            checked        = 0;
            recomputed     = 0;
        end
        else
        begin
            // output word first, so a word accepted on this edge cannot match itself
            if (out_valid && out_ready)
            begin
                if (axis_words_q.size() == 0)
                begin
                    $error("output word with nothing waiting: axis_value %0d updated %0b",
                           axis_value, updated);
                    errors++;
                end
                else
                begin
                    want = axis_words_q.pop_front();
                    checked++;
                    if (axis_value !== want.axis_value)
                    begin
                        $error("axis_value: expected %0d, got %0d", want.axis_value, axis_value);
                        errors++;
                    end
                    if (updated !== want.updated)
                    begin
                        $error("updated: expected %0b, got %0b", want.updated, updated);
                        errors++;
                    end
                end
            end

            if (psel && penable && pready)
            begin
                reg_known = 1'b1;
                reg_want  = '0;
                reg_name  = "";
                case (reg_idx)
                    jads_pkg::REG_CENTER_POS:
                    begin
                        if (pwrite)
                            cfg_center = pwdata[ADC_BITS-1:0];
                        reg_want = 32'(cfg_center);
                        reg_name = "center_pos";
                    end
                    jads_pkg::REG_MAX_POS:
                    begin
                        if (pwrite)
                            cfg_max_pos = pwdata[ADC_BITS:0];
                        reg_want = 32'(cfg_max_pos);
                        reg_name = "max_pos";
                    end
                    jads_pkg::REG_DEAD_ZONE:
                    begin
                        if (pwrite)
                            cfg_dead_zone = pwdata[ADC_BITS-1:0];
                        reg_want = 32'(cfg_dead_zone);
                        reg_name = "dead_zone";
                    end
                    jads_pkg::REG_MIN_CHANGE:
                    begin
                        if (pwrite)
                            cfg_min_change = pwdata[ADC_BITS-1:0];
                        reg_want = 32'(cfg_min_change);
                        reg_name = "min_change";
                    end
                    jads_pkg::REG_INVERT:
                    begin
                        if (pwrite)
                            cfg_invert = pwdata[0];
                        reg_want = 32'(cfg_invert);
                        reg_name = "invert";
                    end
                    default: reg_known = 1'b0;
                endcase
                if (!pwrite && reg_known && prdata !== reg_want)
                begin
                    $error("%s: expected %0h, got %0h", reg_name, reg_want, prdata);
                    errors++;
                end
            end

            if (in_valid && in_ready)
            begin
                want = predict_word(sample);
                if (want.updated)
                    recomputed++;
                axis_words_q.push_back(want);
            end

            pending = axis_words_q.size();
        end
    end

endmodule

@@ test/tb_joystick_axis_deadzone_scaler_unit.sv @@
// testbench top for the joystick axis dead-zone scaler: clock, reset, register
// settings, sample words and receiver stalls; verdict from jads_axis_checker
// depends on jads_pkg, jads_axis_checker and the scaler rtl
`timescale 1ns / 1ps

module tb_joystick_axis_deadzone_scaler_unit;

    localparam int ADC_BITS        = jads_pkg::ADC_BITS_DEF;
    localparam int FULL_SCALE      = jads_pkg::FULL_SCALE_DEF;
    localparam int VALUE_W         = $clog2(FULL_SCALE + 1) + 1;
    localparam int SAMPLE_TOP      = (1 << ADC_BITS) - 1;
    localparam int MAX_POS_TOP     = (1 << (ADC_BITS + 1)) - 1;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 63;
    localparam int TAIL_CYCLES     = 40;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [jads_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd5;

    logic                              clk;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [jads_pkg::APB_ADDR_W-1:0]   paddr;
    logic [jads_pkg::APB_DATA_W-1:0]   pwdata;
    logic [jads_pkg::APB_DATA_W-1:0]   prdata;
    logic                              pready;
    logic                              in_valid;
    logic                              in_ready;
    logic [ADC_BITS-1:0]               sample;
    logic                              out_valid;
    logic                              out_ready;
    logic signed [VALUE_W-1:0]         axis_value;
    logic                              updated;

    int n_errors;
    int n_pending;
    int n_checked;
    int n_recomputed;

    int cycles;
    int n_sent;
    int n_settings;
    bit no_idle;

    // what was last written, used only to aim the samples
    int set_center     = 512;
    int set_max_pos    = 1024;
    int set_dead_zone  = 0;
    int set_min_change = 0;
    int last_sample    = 0;

    joystick_axis_deadzone_scaler_unit #(
        .ADC_BITS   (ADC_BITS),
        .FULL_SCALE (FULL_SCALE)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .axis_value (axis_value),
        .updated    (updated)
    );

    jads_axis_checker #(
        .ADC_BITS   (ADC_BITS),
        .FULL_SCALE (FULL_SCALE)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .axis_value (axis_value),
        .updated    (updated),
        .errors     (n_errors),
        .pending    (n_pending),
        .checked    (n_checked),
        .recomputed (n_recomputed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $error("run stopped after %0d cycles with %0d words outstanding", cycles, n_pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // mostly short gaps, a few long ones, none while no_idle is set
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 50)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic logic [ADC_BITS-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = int'($urandom_range(0, SAMPLE_TOP));
            3, 4:    v = set_center + int'($urandom_range(0, 2 * set_dead_zone + 4))
                         - set_dead_zone - 2;
            5, 6:    v = last_sample + ($urandom_range(0, 1) ? 1 : -1)
                         * (set_min_change + int'($urandom_range(0, 2)) - 1);
            7:       v = $urandom_range(0, 1) ? 0 : SAMPLE_TOP;
            8:       v = set_max_pos + int'($urandom_range(0, 6)) - 3;
            default: v = last_sample;
        endcase
        if (v < 0)
            v = 0;
        if (v > SAMPLE_TOP)
            v = SAMPLE_TOP;
        last_sample = v;
        return ADC_BITS'(v);
    endfunction

    // setup phase, access phase, then back to idle with psel low
    task automatic reg_access(input logic wr, input logic [jads_pkg::REG_IDX_W-1:0] idx,
                              input logic [jads_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_back();
        reg_access(1'b0, jads_pkg::REG_CENTER_POS, '0);
        reg_access(1'b0, jads_pkg::REG_MAX_POS, '0);
        reg_access(1'b0, jads_pkg::REG_DEAD_ZONE, '0);
        reg_access(1'b0, jads_pkg::REG_MIN_CHANGE, '0);
        reg_access(1'b0, jads_pkg::REG_INVERT, '0);
    endtask

    // upper bits carry junk, the registers keep only their own width
    task automatic set_config(input int c, input int m, input int dz, input int mc,
                              input int inv);
        set_center     = c;
        set_max_pos    = m;
        set_dead_zone  = dz;
        set_min_change = mc;
        n_settings++;
        reg_access(1'b1, jads_pkg::REG_CENTER_POS, ($urandom() << ADC_BITS) | 32'(c));
        reg_access(1'b1, jads_pkg::REG_MAX_POS, ($urandom() << (ADC_BITS + 1)) | 32'(m));
        reg_access(1'b1, jads_pkg::REG_DEAD_ZONE, ($urandom() << ADC_BITS) | 32'(dz));
        reg_access(1'b1, jads_pkg::REG_MIN_CHANGE, ($urandom() << ADC_BITS) | 32'(mc));
        reg_access(1'b1, jads_pkg::REG_INVERT, ($urandom() << 1) | 32'(inv));
        read_back();
    endtask

    task automatic send_sample(input logic [ADC_BITS-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        last_sample = int'(s);
        n_sent++;
    endtask

    // wait for every outstanding word to come back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (n_pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // receiver: runs of ready broken by stalls
    initial
    begin
        int burst;
        int stall;
        out_ready <= 1'b0;
        forever
        begin
            burst = int'($urandom_range(1, 20));
            repeat (burst)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall)
                    @(posedge clk);
            end
        end
    end

    initial
    begin
        int c;
        int m;
        int dz;
        int mc;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        in_valid   <= 1'b0;
        sample     <= '0;
        no_idle    = 1'b0;
        n_sent     = 0;
        n_settings = 1;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, then a write and read to an unmapped slot
        read_back();
        reg_access(1'b1, REG_SPARE, $urandom());
        reg_access(1'b0, REG_SPARE, '0);
        read_back();

        // defaults: first sample always taken, repeat rejected at zero min change
        send_sample(10'd0);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd512);
        send_sample(10'd513);
        send_sample(10'd511);
        drain();

        // dead zone edges, min change edges, saturation, invert
        set_config(300, 700, 20, 5, 1);
        send_sample(10'd300);
        send_sample(10'd319);
        send_sample(10'd320);
        send_sample(10'd323);
        send_sample(10'd326);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd280);
        drain();

        // upper range negative, then zero
        set_config(300, 200, 0, 0, 0);
        send_sample(10'd301);
        drain();
        set_config(300, 300, 0, 0, 0);
        send_sample(10'd400);
        drain();

        // widest min change rejects everything; then centre at each end of the range
        set_config(0, MAX_POS_TOP, SAMPLE_TOP, SAMPLE_TOP, 1);
        send_sample(10'd1023);
        drain();
        set_config(0, MAX_POS_TOP, 0, 0, 0);
        send_sample(10'd0);
        send_sample(10'd1023);
        drain();
        set_config(SAMPLE_TOP, 1024, 0, 0, 1);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd1022);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       c = 0;
                1:       c = SAMPLE_TOP;
                2:       c = 512;
                default: c = int'($urandom_range(0, SAMPLE_TOP));
            endcase
            case ($urandom_range(0, 7))
                0:       m = 0;
                1:       m = c;
                2:       m = c + 1;
                3:       m = MAX_POS_TOP;
                4:       m = 1024;
                default: m = c + int'($urandom_range(1, 1100));
            endcase
            if (m > MAX_POS_TOP)
                m = MAX_POS_TOP;
            case ($urandom_range(0, 7))
                0:       dz = 0;
                1:       dz = SAMPLE_TOP;
                2, 3:    dz = int'($urandom_range(0, SAMPLE_TOP));
                default: dz = int'($urandom_range(1, 48));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: mc = 0;
                3:       mc = SAMPLE_TOP;
                4:       mc = int'($urandom_range(0, SAMPLE_TOP));
                default: mc = int'($urandom_range(1, 12));
            endcase
            set_config(c, m, dz, mc, int'($urandom_range(0, 1)));
            no_idle = (phase % 4 == 2);
            repeat (WORDS_PER_PHASE)
                send_sample(pick_sample());
            drain();
            no_idle = 1'b0;
        end

        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("%0d samples sent over %0d register settings", n_sent, n_settings);
        $display("%0d output words checked, %0d of them recomputed", n_checked, n_recomputed);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
